// ===== src/qewc_pkg.sv =====
package qewc_pkg;

   localparam int COUNT_WIDTH     = 8;
   localparam int STATE_WIDTH     = 3;
   localparam int SEG_WIDTH       = 7;
   localparam int PWM_WIDTH       = 10;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 8;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COUNT_MAX    = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COUNT_PRESET = 1'd1;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX_RESET    = 8'd250;
   localparam logic [COUNT_WIDTH-1:0] COUNT_PRESET_RESET = 8'd128;

   typedef struct packed {
      logic a_level;
      logic b_level;
      logic reset_n;
   } req_type;

   typedef struct packed {
      logic [STATE_WIDTH-1:0] tracker_state;
      logic [COUNT_WIDTH-1:0] position;
      logic [SEG_WIDTH-1:0]   seg_low_digit;
      logic [SEG_WIDTH-1:0]   seg_high_digit;
      logic [PWM_WIDTH-1:0]   pwm_compare;
   } rsp_type;

   function automatic logic [SEG_WIDTH-1:0] seg_decode(input logic [3:0] digit);
      logic [SEG_WIDTH-1:0] code;
      case (digit)
         4'h0: code = 7'h3f;
         4'h1: code = 7'h06;
         4'h2: code = 7'h5b;
         4'h3: code = 7'h4f;
         4'h4: code = 7'h66;
         4'h5: code = 7'h6d;
         4'h6: code = 7'h7d;
         4'h7: code = 7'h07;
         4'h8: code = 7'h7f;
         4'h9: code = 7'h67;
         4'ha: code = 7'h77;
         4'hb: code = 7'h7c;
         4'hc: code = 7'h39;
         4'hd: code = 7'h5e;
         4'he: code = 7'h79;
         default: code = 7'h71;
      endcase
      return code;
   endfunction

endpackage

// ===== src/quadrature_encoder_wrap_counter_top.sv =====
// Channel   Ports                                 Direction  Transaction
// req       req_valid, req_stall, req_data        in         one A/B/reset sample
// rsp       rsp_valid, rsp_stall, rsp_data        out        state, count, segments, PWM
// csr       csr_we, csr_index, csr_wdata          in         count_max, count_preset
//
// One sample per clock unless stalled; tracker and count update on each taken sample.
// The result appears in the cycle after the sample, held in the tracker/count registers.
// A new sample is taken whenever the result register is empty or is taken that cycle.
// Reset clears the tracker to init, the count to 128 and the registers to defaults.
module quadrature_encoder_wrap_counter_top (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  qewc_pkg::req_type                         req_data,
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output qewc_pkg::rsp_type                         rsp_data,
   input  logic                                      csr_we,
   input  logic [qewc_pkg::CSR_INDEX_WIDTH-1:0]      csr_index,
   input  logic [qewc_pkg::CSR_DATA_WIDTH-1:0]       csr_wdata
);
   import qewc_pkg::*;

   typedef enum logic [STATE_WIDTH-1:0] {
      ST_INIT = 3'd0,
      ST_LL   = 3'd1,
      ST_HL   = 3'd2,
      ST_HH   = 3'd3,
      ST_LH   = 3'd4
   } tracker_type;

   tracker_type            tracker_ff, tracker_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [COUNT_WIDTH-1:0] max_ff, preset_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   accept;
   logic                   step_up, step_down;
   logic [COUNT_WIDTH:0]   count_inc;
   logic [COUNT_WIDTH-1:0] count_dec;
   logic [COUNT_WIDTH-1:0] count_step;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   assign count_inc = {1'b0, count_ff} + {{COUNT_WIDTH{1'b0}}, 1'b1};
   assign count_dec = count_ff - {{(COUNT_WIDTH-1){1'b0}}, 1'b1};

   always_comb begin
      tracker_in = tracker_ff;
      step_up    = 1'b0;
      step_down  = 1'b0;
      unique case (tracker_ff)
         ST_INIT: begin
            case ({req_data.a_level, req_data.b_level})
               2'b00:   tracker_in = ST_LL;
               2'b10:   tracker_in = ST_HL;
               2'b11:   tracker_in = ST_HH;
               default: tracker_in = ST_LH;
            endcase
         end
         ST_LL: begin
            if (req_data.b_level) begin
               tracker_in = ST_LH;
               step_down  = 1'b1;
            end else if (req_data.a_level) begin
               tracker_in = ST_HL;
               step_up    = 1'b1;
            end
         end
         ST_HL: begin
            if (!req_data.a_level) begin
               tracker_in = ST_LL;
               step_down  = 1'b1;
            end else if (req_data.b_level) begin
               tracker_in = ST_HH;
               step_up    = 1'b1;
            end
         end
         ST_HH: begin
            if (!req_data.b_level) begin
               tracker_in = ST_HL;
               step_down  = 1'b1;
            end else if (!req_data.a_level) begin
               tracker_in = ST_LH;
               step_up    = 1'b1;
            end
         end
         ST_LH: begin
            if (req_data.a_level) begin
               tracker_in = ST_HH;
               step_down  = 1'b1;
            end else if (!req_data.b_level) begin
               tracker_in = ST_LL;
               step_up    = 1'b1;
            end
         end
         default: tracker_in = ST_INIT;
      endcase

      if (count_inc > {1'b0, max_ff}) begin
         count_step = '0;
      end else begin
         count_step = count_inc[COUNT_WIDTH-1:0];
      end
      if (step_down) begin
         if (count_ff == '0 || count_dec > max_ff) begin
            count_step = max_ff;
         end else begin
            count_step = count_dec;
         end
      end

      count_in = (step_up || step_down) ? count_step : count_ff;

      if (!req_data.reset_n) begin
         tracker_in = ST_INIT;
         count_in   = preset_ff;
      end

      rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tracker_ff   <= ST_INIT;
         count_ff     <= COUNT_PRESET_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            tracker_ff <= tracker_in;
            count_ff   <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff    <= COUNT_MAX_RESET;
         preset_ff <= COUNT_PRESET_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_COUNT_MAX:    max_ff    <= csr_wdata[COUNT_WIDTH-1:0];
            CSR_COUNT_PRESET: preset_ff <= csr_wdata[COUNT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp_data.tracker_state  = tracker_ff;
      rsp_data.position       = count_ff;
      rsp_data.seg_low_digit  = seg_decode(count_ff[3:0]);
      rsp_data.seg_high_digit = seg_decode(count_ff[7:4]);
      rsp_data.pwm_compare    = {count_ff, 2'b00};
   end

   a_reset_forces_preset: assert property (@(posedge clock) disable iff (reset)
      accept && !req_data.reset_n |=>
         tracker_ff == ST_INIT && count_ff == $past(preset_ff))
      else $error("sample with reset low did not load init and preset");

   a_count_within_max: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.reset_n && tracker_ff != ST_INIT && count_ff <= max_ff |=>
         count_ff <= $past(max_ff))
      else $error("count step left the range up to count_max");

   a_state_holds_idle: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(count_ff) && $stable(tracker_ff))
      else $error("tracker or count changed without a transaction");

   a_init_no_count: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.reset_n && tracker_ff == ST_INIT |=>
         $stable(count_ff) && tracker_ff != ST_INIT)
      else $error("init state counted or failed to adopt the level pair");

endmodule
